[hdl/hhls_pkg.sv]
`timescale 1ns / 1ps
// Package for the HTTP header line splitter: item types, byte codes,
// register indexes and small helper functions. No dependencies.
package hhls_pkg;

  // Block offsets are 16 bits and saturate at the largest block size
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] BLOCK_BYTES_MAX = 16'hFFFF;

  // Byte codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Record kinds
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_COUNT  = 2'd1;
  localparam logic [CFG_DATA_W-1:0]  MAX_LINE_LENGTH_RESET = 16'd4096;
  localparam logic [CFG_DATA_W-1:0]  MAX_LINE_COUNT_RESET  = 16'd200;

  // Queue between the scanner and the record builder
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Input item
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       discard_unterminated_tail;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic             record_kind;
    logic [POS_W-1:0] line_start;
    logic [POS_W-1:0] line_length;
    logic [POS_W-1:0] colon_offset;
    logic             no_colon;
    logic             line_too_long;
    logic             line_wrapped;
    logic             name_whitespace;
    logic [POS_W-1:0] line_count;
    logic             too_many_lines;
    logic [POS_W-1:0] longest_line;
    logic             last_result;
  } result_t;

  // Raw description of one finished line, as the scanner sees it
  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             colon_seen;
    logic [POS_W-1:0] colon_pos;
    logic             wrapped;
    logic             space_in_name;
  } line_desc_t;

  // Work for one byte: a line closed by a terminator, a tail line at the
  // end of the block, and the block summary, in that order
  typedef struct packed {
    logic       term_valid;
    line_desc_t term_line;
    logic       tail_valid;
    line_desc_t tail_line;
    logic       summary_valid;
  } queue_entry_t;

  function automatic logic is_crlf(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_sptab(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  // Offset minus a small count, clamped at zero
  function automatic logic [POS_W-1:0] end_before(input logic [POS_W-1:0] p,
                                                  input logic [1:0] c);
    logic [POS_W-1:0] cw;
    cw = {{(POS_W-2){1'b0}}, c};
    return (p > cw) ? (p - cw) : '0;
  endfunction

endpackage

[hdl/hhls_front.sv]
`timescale 1ns / 1ps
// Front end of the line splitter: scans one byte per cycle while q_full
// is low, tracks line boundaries and folds, and queues raw line work. Uses hhls_pkg.
module hhls_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hhls_pkg::in_item_t    item,
  input  logic                  q_full,
  output logic                  q_wr,
  output hhls_pkg::queue_entry_t q_data
);

  // Scanner state
  logic [hhls_pkg::POS_W-1:0] position, position_next;
  logic [1:0]                 la_count, la_count_next;
  logic                       la_cr, la_cr_next;
  logic                       in_sep, in_sep_next;
  logic [hhls_pkg::POS_W-1:0] cur_start, cur_start_next;
  logic                       colon_seen, colon_seen_next;
  logic [hhls_pkg::POS_W-1:0] colon_pos, colon_pos_next;
  logic                       wrap_seen, wrap_seen_next;
  logic                       space_in_name, space_in_name_next;

  logic                       accept;
  logic [7:0]                 b;
  logic                       b_crlf, b_sptab, b_colon;
  logic                       start_new;
  logic [hhls_pkg::POS_W-1:0] pos_inc;
  logic [1:0]                 tail_sub;

  assign accept  = push && !q_full;
  assign b       = item.byte_value;
  assign b_crlf  = hhls_pkg::is_crlf(b);
  assign b_sptab = hhls_pkg::is_sptab(b);
  assign b_colon = (b == hhls_pkg::CH_COLON);
  assign pos_inc = (position == hhls_pkg::BLOCK_BYTES_MAX) ? position : position + 1'b1;

  // Classify the byte and work out the next scanner state
  always_comb begin
    position_next      = pos_inc;
    la_count_next      = la_count;
    la_cr_next         = la_cr;
    in_sep_next        = in_sep;
    cur_start_next     = cur_start;
    colon_seen_next    = colon_seen;
    colon_pos_next     = colon_pos;
    wrap_seen_next     = wrap_seen;
    space_in_name_next = space_in_name;
    start_new          = 1'b0;
    q_data             = '0;

    // Line closed by its terminator, described from the current state
    q_data.term_line.start_pos     = cur_start;
    q_data.term_line.end_pos       = hhls_pkg::end_before(position, la_count);
    q_data.term_line.colon_seen    = colon_seen;
    q_data.term_line.colon_pos     = colon_pos;
    q_data.term_line.wrapped       = wrap_seen;
    q_data.term_line.space_in_name = space_in_name;

    if (in_sep) begin
      start_new = !b_crlf;
    end else if (la_count == 2'd0) begin
      if (b_crlf) begin
        la_cr_next    = (b == hhls_pkg::CH_CR);
        la_count_next = 2'd1;
      end else if (!colon_seen) begin
        if (b_colon) begin
          colon_seen_next = 1'b1;
          colon_pos_next  = position;
        end else if (b_sptab) begin
          space_in_name_next = 1'b1;
        end
      end
    end else if (b_sptab) begin
      // fold: pending CR/LF and this blank join the line
      if (!colon_seen) begin
        space_in_name_next = 1'b1;
      end
      wrap_seen_next = 1'b1;
      la_count_next  = 2'd0;
    end else if (la_count == 2'd1 && la_cr && b == hhls_pkg::CH_LF) begin
      la_count_next = 2'd2;
    end else begin
      q_data.term_valid = 1'b1;
      in_sep_next       = 1'b1;
      la_count_next     = 2'd0;
      start_new         = !b_crlf;
    end

    if (start_new) begin
      in_sep_next        = 1'b0;
      cur_start_next     = position;
      colon_seen_next    = b_colon;
      colon_pos_next     = b_colon ? position : '0;
      wrap_seen_next     = 1'b0;
      space_in_name_next = b_sptab;
      la_count_next      = 2'd0;
    end

    // Tail line at the end of the block, from the updated state
    tail_sub = (la_count_next != 2'd0) ? la_count_next : {1'b0, b_crlf};
    q_data.tail_valid = item.last_byte && !in_sep_next &&
                        (la_count_next != 2'd0 || b_crlf ||
                         !item.discard_unterminated_tail);
    q_data.tail_line.start_pos     = cur_start_next;
    q_data.tail_line.end_pos       = hhls_pkg::end_before(pos_inc, tail_sub);
    q_data.tail_line.colon_seen    = colon_seen_next;
    q_data.tail_line.colon_pos     = colon_pos_next;
    q_data.tail_line.wrapped       = wrap_seen_next;
    q_data.tail_line.space_in_name = space_in_name_next;
    q_data.summary_valid           = item.last_byte;

    // End of block: back to the opening state
    if (item.last_byte) begin
      position_next      = '0;
      la_count_next      = 2'd0;
      la_cr_next         = 1'b0;
      in_sep_next        = 1'b1;
      cur_start_next     = '0;
      colon_seen_next    = 1'b0;
      colon_pos_next     = '0;
      wrap_seen_next     = 1'b0;
      space_in_name_next = 1'b0;
    end
  end

  assign q_wr = accept && (q_data.term_valid || q_data.tail_valid || q_data.summary_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      la_count      <= 2'd0;
      la_cr         <= 1'b0;
      in_sep        <= 1'b1;
      cur_start     <= '0;
      colon_seen    <= 1'b0;
      colon_pos     <= '0;
      wrap_seen     <= 1'b0;
      space_in_name <= 1'b0;
    end else if (accept) begin
      position      <= position_next;
      la_count      <= la_count_next;
      la_cr         <= la_cr_next;
      in_sep        <= in_sep_next;
      cur_start     <= cur_start_next;
      colon_seen    <= colon_seen_next;
      colon_pos     <= colon_pos_next;
      wrap_seen     <= wrap_seen_next;
      space_in_name <= space_in_name_next;
    end
  end

`ifndef NO_ASSERTIONS
  // between lines nothing is pending
  a_sep_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_sep |-> la_count == 2'd0)
    else $error("pending CR/LF while between lines");

  // at most CR LF is ever pending
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    la_count != 2'd3)
    else $error("pending count out of range");

  // the last byte of a block restarts the scanner
  a_block_restart: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> in_sep && position == '0)
    else $error("scanner not cleared after block end");
`endif

endmodule

[hdl/hhls_queue.sv]
`timescale 1ns / 1ps
// Short queue of per-byte line work between scanner and record builder.
// Uses hhls_pkg for the entry type and depth.
module hhls_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  hhls_pkg::queue_entry_t wdata,
  output logic                   full,
  input  logic                   rd,
  output hhls_pkg::queue_entry_t rdata,
  output logic                   empty
);

  hhls_pkg::queue_entry_t mem [hhls_pkg::QUEUE_DEPTH];
  logic [hhls_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [hhls_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_wr, do_rd;

  assign full  = (count == hhls_pkg::QUEUE_CNT_W'(hhls_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/hhls_back.sv]
`timescale 1ns / 1ps
// Back end of the line splitter: turns queued line work into records one a
// cycle unless the output stalls on pop, keeps the block counters and the registers. Uses hhls_pkg.
module hhls_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [hhls_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [hhls_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   q_empty,
  input  hhls_pkg::queue_entry_t                 q_data,
  output logic                                   q_rd,
  input  logic                                   pop,
  output logic                                   empty,
  output hhls_pkg::result_t                      result
);

  logic [hhls_pkg::CFG_DATA_W-1:0] max_line_length, max_line_count;
  logic [hhls_pkg::POS_W-1:0]      lines, longest;
  logic [2:0]                      done;
  logic                            out_valid;

  logic [2:0]                 avail, remaining, pick;
  logic                       advance, emit;
  hhls_pkg::line_desc_t       d;
  logic [hhls_pkg::POS_W-1:0] len, craw, coff;
  hhls_pkg::result_t          result_next;

  // Records still owed for the entry at the head of the queue
  assign avail     = q_empty ? 3'b000 :
                     {q_data.summary_valid, q_data.tail_valid, q_data.term_valid};
  assign remaining = avail & ~done;
  assign advance   = !out_valid || pop;

  always_comb begin
    if (remaining[0]) begin
      pick = 3'b001;
    end else if (remaining[1]) begin
      pick = 3'b010;
    end else if (remaining[2]) begin
      pick = 3'b100;
    end else begin
      pick = 3'b000;
    end
  end

  assign emit = advance && (pick != 3'b000);
  assign q_rd = advance && !q_empty && ((remaining & ~pick) == 3'b000);

  // Line arithmetic
  assign d    = pick[0] ? q_data.term_line : q_data.tail_line;
  assign len  = (d.end_pos > d.start_pos) ? d.end_pos - d.start_pos : '0;
  assign craw = (d.colon_pos > d.start_pos) ? d.colon_pos - d.start_pos : '0;
  assign coff = d.colon_seen ? ((craw > len) ? len : craw) : '0;

  // Build the record
  always_comb begin
    result_next = '0;
    if (pick[2]) begin
      result_next.record_kind    = hhls_pkg::KIND_SUMMARY;
      result_next.line_count     = lines;
      result_next.too_many_lines = (lines > max_line_count);
      result_next.longest_line   = longest;
      result_next.last_result    = 1'b1;
    end else begin
      result_next.record_kind     = hhls_pkg::KIND_LINE;
      result_next.line_start      = d.start_pos;
      result_next.line_length     = len;
      result_next.colon_offset    = coff;
      result_next.no_colon        = !d.colon_seen;
      result_next.line_too_long   = (len > max_line_length);
      result_next.line_wrapped    = d.wrapped;
      result_next.name_whitespace = d.colon_seen && d.space_in_name;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

  assign empty = !out_valid;

  // Control, counters and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      done            <= 3'b000;
      lines           <= '0;
      longest         <= '0;
      max_line_length <= hhls_pkg::MAX_LINE_LENGTH_RESET;
      max_line_count  <= hhls_pkg::MAX_LINE_COUNT_RESET;
    end else begin
      if (advance) begin
        out_valid <= emit;
      end
      if (q_rd) begin
        done <= 3'b000;
      end else if (emit) begin
        done <= done | pick;
      end
      if (emit) begin
        if (pick[2]) begin
          lines   <= '0;
          longest <= '0;
        end else begin
          if (lines != '1) begin
            lines <= lines + 1'b1;
          end
          if (len > longest) begin
            longest <= len;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          hhls_pkg::REG_MAX_LINE_LENGTH: max_line_length <= cfg_data;
          hhls_pkg::REG_MAX_LINE_COUNT:  max_line_count  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // only records the entry really holds are marked delivered
  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (done & ~avail) == 3'b000)
    else $error("delivered mark on a record the entry lacks");

  // a summary closes the block counters
  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    emit && pick[2] |=> lines == '0 && longest == '0)
    else $error("block counters not cleared after summary");

  // nothing is taken from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("queue read while empty");
`endif

endmodule

[hdl/http_header_line_splitter_unit.sv]
`timescale 1ns / 1ps
// Top level of the HTTP header line splitter: scanner, work queue and
// record builder. Uses hhls_pkg, hhls_front, hhls_queue and hhls_back.
//
//   Channel   Handshake          Payload
//   input     push / full        item   (byte_value, last_byte, discard tail)
//   result    empty / pop        result (line record or block summary)
//   config    cfg_we             cfg_index, cfg_data (16 bits)
//
// One byte is taken every cycle while full is low; the scanner state advances
// in that cycle. A byte yields zero to three records (line closed, tail
// line, summary); the record builder hands out one per cycle while pop keeps
// up, so bytes that yield several records are absorbed by the four-entry
// work queue, and full rises when it fills. Reset is synchronous; no clearing
// pass. A stall on pop backs up through the output register into the queue.
module http_header_line_splitter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  hhls_pkg::in_item_t               item,
  output logic                             empty,
  input  logic                             pop,
  output hhls_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [hhls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hhls_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                   q_wr, q_rd, q_full, q_empty;
  hhls_pkg::queue_entry_t q_wdata, q_rdata;

  assign full = q_full;

  // byte scanner
  hhls_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  // work queue
  hhls_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // record builder
  hhls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
